FILE: hw/rtl/cls_pkg.sv
// cls_pkg: types and constants shared by the clipped line stepper.
// Holds the line state and point structs and the register index codes.
// No dependencies.
`timescale 1ns / 1ps

package cls_pkg;

    // Function codes of an input transaction
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 2'd3;
    localparam int unsigned CFG_DATA_W = 13;

    // Field widths
    localparam int unsigned COORD_W = 16;
    localparam int unsigned ORIGIN_W = 12;
    localparam int unsigned EXTENT_W = 13;
    localparam int unsigned PIXEL_W = 13;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned ERR_W = 18;

    // Register reset values
    localparam logic [EXTENT_W-1:0] CLIP_EXTENT_RST = 13'd4096;

    // Bresenham state of the line being drawn
    typedef struct packed {
        logic signed [COORD_W-1:0] cur_x;
        logic signed [COORD_W-1:0] cur_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                      dir_x;   // 1 = stepping negative
        logic                      dir_y;
        logic [COORD_W-1:0]        span_x;
        logic [COORD_W-1:0]        span_y;
        logic signed [ERR_W-1:0]   err;
    } t_line_state;

    // Clipping window
    typedef struct packed {
        logic [ORIGIN_W-1:0] left;
        logic [ORIGIN_W-1:0] top;
        logic [EXTENT_W-1:0] width;
        logic [EXTENT_W-1:0] height;
    } t_clip;

    // One produced point, colour excepted
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_x;
        logic [PIXEL_W-1:0] pixel_y;
        logic               visible;
        logic               last;
    } t_point;

endpackage

FILE: hw/rtl/cls_if.sv
// cls_if: valid/ready channel interfaces of the clipped line stepper.
// Input, result and configuration write channels. Depends on cls_pkg.
`timescale 1ns / 1ps

interface cls_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic signed [cls_pkg::COORD_W-1:0]   start_x;
    logic signed [cls_pkg::COORD_W-1:0]   start_y;
    logic signed [cls_pkg::COORD_W-1:0]   finish_x;
    logic signed [cls_pkg::COORD_W-1:0]   finish_y;
    logic [cls_pkg::COLOR_W-1:0]          color_in;

    modport source (output valid, func, start_x, start_y, finish_x, finish_y, color_in,
                    input ready);
    modport sink   (input valid, func, start_x, start_y, finish_x, finish_y, color_in,
                    output ready);
endinterface

interface cls_out_if;
    logic                          valid;
    logic                          ready;
    logic [cls_pkg::PIXEL_W-1:0]   pixel_x;
    logic [cls_pkg::PIXEL_W-1:0]   pixel_y;
    logic [cls_pkg::COLOR_W-1:0]   color_out;
    logic                          visible;
    logic                          last;

    modport source (output valid, pixel_x, pixel_y, color_out, visible, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, color_out, visible, last, output ready);
endinterface

interface cls_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cls_pkg::CFG_IDX_W-1:0]    index;
    logic [cls_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/cls_point_eval.sv
// cls_point_eval: clips the current point and computes the next Bresenham step.
// Purely combinational. Depends on cls_pkg.
`timescale 1ns / 1ps

module cls_point_eval #(
    parameter int unsigned MAX_POINTS = 8192,
    parameter int unsigned CNT_W      = 14
) (
    input  cls_pkg::t_line_state i_state,
    input  logic [CNT_W-1:0]     i_count,
    input  cls_pkg::t_clip       i_clip,
    output cls_pkg::t_point      o_point,
    output cls_pkg::t_line_state o_next
);

    localparam int unsigned CW = cls_pkg::COORD_W;
    localparam int unsigned EW = cls_pkg::ERR_W;

    logic                  vis;
    logic                  at_end;
    logic signed [EW:0]    e2;
    logic signed [EW:0]    span_x_w;
    logic signed [EW:0]    span_y_w;
    logic                  step_x;
    logic                  step_y;
    logic signed [EW-1:0]  err_x;

    // Window test: non-negative and below the extent
    always_comb begin
        vis = !i_state.cur_x[CW-1] && !i_state.cur_y[CW-1]
              && ({1'b0, i_state.cur_x[CW-2:0]} < {3'b000, i_clip.width})
              && ({1'b0, i_state.cur_y[CW-2:0]} < {3'b000, i_clip.height});
        at_end = (i_state.cur_x == i_state.end_x) && (i_state.cur_y == i_state.end_y);
    end

    // Point out, coordinates wrap at 13 bits
    always_comb begin
        o_point.visible = vis;
        o_point.last    = at_end || (i_count == CNT_W'(MAX_POINTS - 1));
        o_point.pixel_x = '0;
        o_point.pixel_y = '0;
        if (vis) begin
            o_point.pixel_x = {1'b0, i_clip.left} + i_state.cur_x[cls_pkg::PIXEL_W-1:0];
            o_point.pixel_y = {1'b0, i_clip.top} + i_state.cur_y[cls_pkg::PIXEL_W-1:0];
        end
    end

    // Error step: e2 = 2*err against -span_y and span_x
    always_comb begin
        e2       = {i_state.err, 1'b0};
        span_x_w = $signed({3'b000, i_state.span_x});
        span_y_w = $signed({3'b000, i_state.span_y});
        step_x   = e2 > -span_y_w;
        step_y   = e2 < span_x_w;
        o_next   = i_state;
        err_x    = i_state.err;
        if (step_x) begin
            err_x        = i_state.err - $signed({2'b00, i_state.span_y});
            o_next.cur_x = i_state.dir_x ? i_state.cur_x - 16'sd1 : i_state.cur_x + 16'sd1;
        end
        o_next.err = err_x;
        if (step_y) begin
            o_next.err   = err_x + $signed({2'b00, i_state.span_x});
            o_next.cur_y = i_state.dir_y ? i_state.cur_y - 16'sd1 : i_state.cur_y + 16'sd1;
        end
    end

endmodule

FILE: hw/rtl/clipped_line_stepper.sv
// clipped_line_stepper: Bresenham line stepper with window clipping, top level.
// Depends on cls_pkg, cls_if (channel interfaces) and cls_point_eval.
//
// Usage:
//   i_in carries transactions with func = load or advance. A load takes the
//   window-relative endpoints and colour, sets up the line and gives no result.
//   Each advance while a line is running gives one point on o_out: absolute
//   screen coordinates (window origin added, zero when hidden), the visible
//   flag, the colour, and last on the endpoint or the MAX_POINTS-th point,
//   after which the block is idle. An advance while idle is consumed silently.
//   i_cfg writes the clip window registers (left, top, width, height); it is
//   always ready and should be used only while no line output is pending.
// Timing:
//   A result appears in the output register in the cycle after its advance
//   is accepted. One transaction per cycle is sustained while o_out.ready
//   is high; the line state registers and cls_point_eval form the step loop.
// Reset and stall:
//   Synchronous reset clears the line to idle and the window to 0/0/4096/4096.
//   While a result waits in the output register and o_out.ready is low,
//   i_in.ready is low; it is high whenever the output register is empty or
//   being drained in the same cycle.
`timescale 1ns / 1ps

module clipped_line_stepper #(
    parameter int unsigned MAX_POINTS = 8192
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cls_in_if.sink        i_in,
    cls_out_if.source     o_out,
    cls_cfg_if.sink       i_cfg
);

    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
    localparam int unsigned CW    = cls_pkg::COORD_W;

    cls_pkg::t_clip        r_clip;
    cls_pkg::t_line_state  r_state;
    cls_pkg::t_line_state  n_state;
    cls_pkg::t_line_state  load_state;
    cls_pkg::t_point       point;
    logic [CNT_W-1:0]      r_count;
    logic                  r_busy;
    logic [cls_pkg::COLOR_W-1:0] r_color;

    logic                  r_out_valid;
    cls_pkg::t_point       r_out_point;
    logic [cls_pkg::COLOR_W-1:0] r_out_color;

    logic                  in_fire;
    logic                  adv_fire;
    logic signed [CW:0]    dx;
    logic signed [CW:0]    dy;
    logic [CW:0]           abs_x;
    logic [CW:0]           abs_y;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign adv_fire    = in_fire && (i_in.func == cls_pkg::FUNC_ADVANCE) && r_busy;

    // Line setup from a load transaction
    always_comb begin
        dx    = $signed({i_in.finish_x[CW-1], i_in.finish_x})
                - $signed({i_in.start_x[CW-1], i_in.start_x});
        dy    = $signed({i_in.finish_y[CW-1], i_in.finish_y})
                - $signed({i_in.start_y[CW-1], i_in.start_y});
        abs_x = dx[CW] ? CW'(0) - dx : dx;
        abs_y = dy[CW] ? CW'(0) - dy : dy;
        load_state.cur_x  = i_in.start_x;
        load_state.cur_y  = i_in.start_y;
        load_state.end_x  = i_in.finish_x;
        load_state.end_y  = i_in.finish_y;
        load_state.dir_x  = dx[CW];
        load_state.dir_y  = dy[CW];
        load_state.span_x = abs_x[CW-1:0];
        load_state.span_y = abs_y[CW-1:0];
        load_state.err    = $signed({2'b00, abs_x[CW-1:0]}) - $signed({2'b00, abs_y[CW-1:0]});
    end

    // Clip and step of the current point
    cls_point_eval #(
        .MAX_POINTS (MAX_POINTS),
        .CNT_W      (CNT_W)
    ) u_eval (
        .i_state (r_state),
        .i_count (r_count),
        .i_clip  (r_clip),
        .o_point (point),
        .o_next  (n_state)
    );

    // Window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip.left   <= '0;
            r_clip.top    <= '0;
            r_clip.width  <= cls_pkg::CLIP_EXTENT_RST;
            r_clip.height <= cls_pkg::CLIP_EXTENT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                cls_pkg::CFG_CLIP_LEFT:   r_clip.left   <= i_cfg.data[cls_pkg::ORIGIN_W-1:0];
                cls_pkg::CFG_CLIP_TOP:    r_clip.top    <= i_cfg.data[cls_pkg::ORIGIN_W-1:0];
                cls_pkg::CFG_CLIP_WIDTH:  r_clip.width  <= i_cfg.data;
                cls_pkg::CFG_CLIP_HEIGHT: r_clip.height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_count <= '0;
            r_busy  <= 1'b0;
            r_color <= '0;
        end else if (in_fire && (i_in.func == cls_pkg::FUNC_LOAD)) begin
            r_state <= load_state;
            r_count <= '0;
            r_busy  <= 1'b1;
            r_color <= i_in.color_in;
        end else if (adv_fire) begin
            r_count <= r_count + CNT_W'(1);
            if (point.last) begin
                r_busy <= 1'b0;
            end else begin
                r_state <= n_state;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_fire) begin
            r_out_point <= point;
            r_out_color <= r_color;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pixel_x   = r_out_point.pixel_x;
    assign o_out.pixel_y   = r_out_point.pixel_y;
    assign o_out.visible   = r_out_point.visible;
    assign o_out.last      = r_out_point.last;
    assign o_out.color_out = r_out_color;

endmodule

FILE: test/cls_line_checker.sv
// cls_line_checker: watches the channels of the clipped line stepper, predicts
// every point from its own copy of the line state and window, and counts misses.
// Depends on cls_pkg and cls_if.
`timescale 1ns / 1ps

module cls_line_checker
    import cls_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 8192
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cls_in_if    i_in,
    cls_out_if   i_out,
    cls_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    // One predicted point with its colour
    typedef struct {
        t_point             pt;
        logic [COLOR_W-1:0] color;
    } t_expected_point;

    t_line_state        line_st;
    t_clip              window;
    logic [COLOR_W-1:0] line_color;
    logic [13:0]        point_count;
    logic               line_busy;
    t_expected_point    expected_points[$];
    int                 fails = 0;

    // Set up spans, directions and error term of a new line
    task automatic load_line(input logic signed [COORD_W-1:0] sx, sy, fx, fy,
                             input logic [COLOR_W-1:0] col);
        int dx;
        int dy;
        int ax;
        int ay;
        dx = int'(fx) - int'(sx);
        dy = int'(fy) - int'(sy);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        line_st.cur_x  = sx;
        line_st.cur_y  = sy;
        line_st.end_x  = fx;
        line_st.end_y  = fy;
        line_st.dir_x  = (dx < 0);
        line_st.dir_y  = (dy < 0);
        line_st.span_x = COORD_W'(ax);
        line_st.span_y = COORD_W'(ay);
        line_st.err    = ERR_W'(ax - ay);
        line_color     = col;
        point_count    = '0;
        line_busy      = 1'b1;
    endtask

    // Emit the current point, then take one Bresenham step
    task automatic trace_point();
        int              cx;
        int              cy;
        int              sx;
        int              sy;
        int              e2;
        int              er;
        logic            vis;
        logic            fin;
        t_expected_point want;
        cx  = int'($signed(line_st.cur_x));
        cy  = int'($signed(line_st.cur_y));
        sx  = int'(line_st.span_x);
        sy  = int'(line_st.span_y);
        er  = int'($signed(line_st.err));
        vis = (cx >= 0) && (cy >= 0) && (cx < int'(window.width)) && (cy < int'(window.height));
        fin = (line_st.cur_x == line_st.end_x && line_st.cur_y == line_st.end_y) ||
              (int'(point_count) + 1 >= int'(MAX_POINTS));
        // coordinates wrap to the pixel width on a wide window
        want.pt.pixel_x = vis ? PIXEL_W'(int'(window.left) + cx) : '0;
        want.pt.pixel_y = vis ? PIXEL_W'(int'(window.top) + cy) : '0;
        want.pt.visible = vis;
        want.pt.last    = fin;
        want.color      = line_color;
        expected_points.push_back(want);
        if (fin) begin
            line_busy = 1'b0;
        end else begin
            e2 = er * 2;
            if (e2 > -sy) begin
                er -= sy;
                cx += line_st.dir_x ? -1 : 1;
            end
            if (e2 < sx) begin
                er += sx;
                cy += line_st.dir_y ? -1 : 1;
            end
            line_st.cur_x = COORD_W'(cx);
            line_st.cur_y = COORD_W'(cy);
            line_st.err   = ERR_W'(er);
        end
        point_count = point_count + 14'd1;
    endtask

    // Compare a delivered point with the oldest prediction
    task automatic check_point();
        t_expected_point want;
        if (expected_points.size() == 0) begin
            $error("point with none predicted: x=%0d y=%0d", i_out.pixel_x, i_out.pixel_y);
            fails++;
        end else begin
            want = expected_points.pop_front();
            if (i_out.pixel_x !== want.pt.pixel_x) begin
                $error("pixel_x: expected %0d, got %0d", want.pt.pixel_x, i_out.pixel_x);
                fails++;
            end
            if (i_out.pixel_y !== want.pt.pixel_y) begin
                $error("pixel_y: expected %0d, got %0d", want.pt.pixel_y, i_out.pixel_y);
                fails++;
            end
            if (i_out.color_out !== want.color) begin
                $error("color_out: expected %h, got %h", want.color, i_out.color_out);
                fails++;
            end
            if (i_out.visible !== want.pt.visible) begin
                $error("visible: expected %0b, got %0b", want.pt.visible, i_out.visible);
                fails++;
            end
            if (i_out.last !== want.pt.last) begin
                $error("last: expected %0b, got %0b", want.pt.last, i_out.last);
                fails++;
            end
        end
    endtask

    // Outputs are compared before inputs: a point never leaves in the cycle
    // of its own advance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_st        = '0;
            window.left    = '0;
            window.top     = '0;
            window.width   = CLIP_EXTENT_RST;
            window.height  = CLIP_EXTENT_RST;
            line_color     = '0;
            point_count    = '0;
            line_busy      = 1'b0;
            expected_points.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_CLIP_LEFT:   window.left   = i_cfg.data[ORIGIN_W-1:0];
                    CFG_CLIP_TOP:    window.top    = i_cfg.data[ORIGIN_W-1:0];
                    CFG_CLIP_WIDTH:  window.width  = i_cfg.data[EXTENT_W-1:0];
                    CFG_CLIP_HEIGHT: window.height = i_cfg.data[EXTENT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                check_point();
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.func == FUNC_LOAD) begin
                    load_line(i_in.start_x, i_in.start_y, i_in.finish_x, i_in.finish_y,
                              i_in.color_in);
                end else if (line_busy) begin
                    trace_point();
                end
            end
        end
        o_pending    <= expected_points.size();
        o_fail_count <= fails;
    end

endmodule

FILE: test/tb_clipped_line_stepper.sv
// tb_clipped_line_stepper: drives loads, advances and window writes into the
// clipped line stepper under varied idling and gives the verdict.
// Depends on cls_pkg, cls_if, clipped_line_stepper and cls_line_checker.
`timescale 1ns / 1ps

module tb_clipped_line_stepper;
    import cls_pkg::*;

    localparam int unsigned LINE_POINT_CAP = 8192;
    localparam int RX_HOLD_CYCLES = 48;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int ADVANCE_CAP    = 90;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   points_pending;
    int   tx_idle_pct   = 0;
    int   rx_idle_pct   = 0;
    int   hold_requests = 0;
    int   holds_served  = 0;

    cls_in_if  in_ch();
    cls_out_if out_ch();
    cls_cfg_if cfg_ch();

    clipped_line_stepper #(
        .MAX_POINTS(LINE_POINT_CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    cls_line_checker #(
        .MAX_POINTS(LINE_POINT_CAP)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg       (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (points_pending)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Point receiver: random back-pressure, or a long hold when asked
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served = holds_served + 1;
                out_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    // Offer one transaction, with random gaps before it, and wait for acceptance
    task automatic send_transaction(input logic fn,
                                    input logic signed [COORD_W-1:0] sx, sy, fx, fy,
                                    input logic [COLOR_W-1:0] col);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.func     <= fn;
        in_ch.start_x  <= sx;
        in_ch.start_y  <= sy;
        in_ch.finish_x <= fx;
        in_ch.finish_y <= fy;
        in_ch.color_in <= col;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Advance with junk in the unused fields
    task automatic send_advance();
        send_transaction(FUNC_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         $urandom);
    endtask

    // Stop offering and wait until every predicted point has been delivered
    task automatic wait_points_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (points_pending != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Window writes only once the stepper has gone quiet
    task automatic set_window(input logic [CFG_DATA_W-1:0] left, top, width, height);
        wait_points_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_register(CFG_CLIP_LEFT, left);
        write_register(CFG_CLIP_TOP, top);
        write_register(CFG_CLIP_WIDTH, width);
        write_register(CFG_CLIP_HEIGHT, height);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly complete short lines with random content; some cut short by a
    // new load, some followed by advances on an idle stepper, and some noise.
    task automatic draw_random_lines(input int n_items);
        int sent;
        int sx;
        int sy;
        int dx;
        int dy;
        int fx;
        int fy;
        int len;
        int span;
        int adv;
        int r;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 75) begin
                    sx = int'($urandom_range(220)) - 20;
                    sy = int'($urandom_range(220)) - 20;
                end else begin
                    sx = int'(rand_coord());
                    sy = int'(rand_coord());
                end
                if ($urandom_range(9) == 0) begin
                    dx = int'($urandom_range(80)) - 40;
                    dy = int'($urandom_range(80)) - 40;
                end else begin
                    dx = int'($urandom_range(24)) - 12;
                    dy = int'($urandom_range(24)) - 12;
                end
                // endpoints may wrap at the extremes, giving a very long line
                fx   = int'($signed(COORD_W'(sx + dx)));
                fy   = int'($signed(COORD_W'(sy + dy)));
                len  = (fx > sx) ? fx - sx : sx - fx;
                span = (fy > sy) ? fy - sy : sy - fy;
                if (span > len) len = span;
                len++;
                r = $urandom_range(99);
                if (r < 70) adv = len;
                else if (r < 85) adv = $urandom_range(1, len);
                else adv = len + $urandom_range(1, 3);
                if (adv > ADVANCE_CAP) adv = ADVANCE_CAP;
                send_transaction(FUNC_LOAD, COORD_W'(sx), COORD_W'(sy), COORD_W'(fx),
                                 COORD_W'(fy), $urandom);
                repeat (adv) send_advance();
                sent += 1 + ((adv < len) ? adv : len);
            end else begin
                send_transaction(logic'($urandom_range(1)), rand_coord(), rand_coord(),
                                 rand_coord(), rand_coord(), $urandom);
                sent++;
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.func     <= FUNC_ADVANCE;
        in_ch.start_x  <= '0;
        in_ch.start_y  <= '0;
        in_ch.finish_x <= '0;
        in_ch.finish_y <= '0;
        in_ch.color_in <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_CLIP_LEFT;
        cfg_ch.data    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset window, advance on an idle stepper, a short line
        // run past its end, a full-range line dropped by a new load.
        send_advance();
        send_transaction(FUNC_LOAD, 16'sd0, 16'sd0, 16'sd3, 16'sd1, 32'hFFFF_FFFF);
        repeat (5) send_advance();
        send_transaction(FUNC_LOAD, 16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767,
                         32'h0000_0000);
        repeat (2) send_advance();
        send_transaction(FUNC_LOAD, 16'sd32767, 16'sd32767, 16'sd32765, 16'sd32766,
                         32'hA5A5_5A5A);
        repeat (3) send_advance();
        // vertical line across the bottom edge of the window
        send_transaction(FUNC_LOAD, 16'sd5, 16'sd4095, 16'sd5, 16'sd4097, 32'h1234_5678);
        repeat (3) send_advance();

        // Wide window at the far corner: sums wrap to the pixel width
        set_window(13'd4095, 13'd4095, 13'd8191, 13'd8191);
        send_transaction(FUNC_LOAD, 16'sd4094, 16'sd4095, 16'sd4097, 16'sd4096, 32'h0F0F_F0F0);
        repeat (4) send_advance();

        // Empty window: nothing visible
        set_window(13'd0, 13'd0, 13'd0, 13'd0);
        send_transaction(FUNC_LOAD, 16'sd0, 16'sd0, -16'sd1, -16'sd1, 32'h8000_0001);
        repeat (2) send_advance();

        // Random part with a slow receiver, and a full drain half way
        set_window(CFG_DATA_W'($urandom_range(4095)), CFG_DATA_W'($urandom_range(4095)),
                   CFG_DATA_W'($urandom_range(40, 160)), CFG_DATA_W'($urandom_range(40, 160)));
        tx_idle_pct <= 31;
        rx_idle_pct <= 87;
        draw_random_lines(125);
        wait_points_drained();
        draw_random_lines(125);

        // Slow sender, extreme origin with the reset extents
        set_window(13'd4095, 13'd4095, 13'd4096, 13'd4096);
        tx_idle_pct <= 87;
        rx_idle_pct <= 31;
        draw_random_lines(175);

        // Full rate; left written with all bits set is masked to its width
        set_window(13'h1FFF, CFG_DATA_W'($urandom_range(4095)), 13'd8191, 13'd8191);
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        draw_random_lines(125);
        // long receiver hold while advances keep coming: the stepper backs up
        send_transaction(FUNC_LOAD, 16'sd0, 16'sd0, 16'sd60, 16'sd20, $urandom);
        hold_requests <= hold_requests + 1;
        repeat (61) send_advance();
        draw_random_lines(125);

        wait_points_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
